[sv/bpl_pkg.sv]
// shared types, constants and arithmetic helpers of the block peak limiter
package bpl_pkg;

   localparam logic [16:0] GAIN_ONE     = 17'd65536;
   localparam logic [14:0] CEIL_LOW     = 15'd30000;
   localparam logic [14:0] CEIL_HIGH    = 15'd32700;
   localparam logic [4:0]  DIV_STEPS    = 5'd16;
   // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT for x below 2^22
   localparam logic [19:0] RECIP_TEN    = 20'd838861;
   localparam int          RECIP_SHIFT  = 23;

   typedef enum logic [0:0] {
      CSR_LIMIT_ENABLE = 1'b0,
      CSR_CEILING      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [24:0] sample_in;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               run_last;
   } rsp_type;

   // tag that follows one store read down the scaling pipe
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quot;
   } div_res_type;

   function automatic logic [14:0] clamp_ceiling(input logic [14:0] c);
      logic [14:0] r;
      r = c;
      if (c < CEIL_LOW) r = CEIL_LOW;
      if (c > CEIL_HIGH) r = CEIL_HIGH;
      return r;
   endfunction

   // per-sample clamp to +-32767 and round half up from q.8
   function automatic logic signed [15:0] clamp_round(input logic signed [24:0] v);
      logic signed [25:0] t;
      logic signed [25:0] s;
      logic signed [15:0] r;
      t = $signed({v[24], v}) + 26'sd128;
      s = t >>> 8;
      if (v > 25'sd8388352) r = 16'sd32767;
      else if (v < -25'sd8388352) r = -16'sd32767;
      else r = s[15:0];
      return r;
   endfunction

   // round half up from q.24 and saturate to 16 bits
   function automatic logic signed [15:0] round_sat(input logic signed [42:0] p);
      logic signed [42:0] t;
      logic signed [42:0] s;
      logic signed [15:0] r;
      t = p + 43'sd8388608;
      s = t >>> 24;
      if (s > 43'sd32767) r = 16'sd32767;
      else if (s < -43'sd32768) r = -16'sd32768;
      else r = s[15:0];
      return r;
   endfunction

endpackage

[sv/block_peak_limiter_core.sv]
// block peak limiter: limiting off registers its result, valid in the cycle after the input transfer.
// limiting on: a sample that does not close a block is stored and gives nothing;
// a closing sample over the ceiling goes through the bit-serial divider, then the store
// is read back through a 3-stage read/multiply/round pipe at one result per cycle unless the
// output stalls, then ST_DRAIN updates the hold and ST_GROW_MUL and ST_GROW_DIV raise the gain.
// reset (synchronous) clears control state, sets unity gain and ceiling 32700; store data is kept.
module block_peak_limiter_core #(
   parameter int BLOCK_DEPTH = 64,
   parameter int HOLD_BLOCKS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bpl_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bpl_pkg::rsp_type       rsp_data,
   input  logic                   csr_write,
   input  bpl_pkg::csr_index_type csr_index,
   input  logic [14:0]            csr_data
);

   localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
   localparam int FW = $clog2(BLOCK_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_DRAIN,
      ST_GROW_MUL,
      ST_GROW_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic                 limit_ff, limit_in;
   logic [14:0]          ceiling_ff, ceiling_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [FW-1:0]        blk_len_ff, blk_len_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic [24:0]          peak_ff, peak_in;
   logic [16:0]          gain_ff, gain_in;
   logic [2:0]           hold_ff, hold_in;
   logic [19:0]          g11_ff, g11_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bpl_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                 advance;
   logic                 req_fire;
   logic [24:0]          mag;
   logic [24:0]          peak_new;
   logic [FW-1:0]        fill_new;
   logic [2:0]           hold_dec;
   logic [39:0]          grow_prod;
   logic [16:0]          grow_q;
   logic                 emit_last;

   logic                 st_wr_en;
   logic                 st_rd_en;
   logic signed [24:0]   st_rd_data;
   logic                 div_start;
   bpl_pkg::div_res_type div_res;
   bpl_pkg::tag_type     issue;
   bpl_pkg::tag_type     res_tag;
   logic signed [15:0]   res_sample;
   logic                 scale_busy;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      mag       = req_data.sample_in[24] ? 25'(~req_data.sample_in + 25'd1)
                                         : req_data.sample_in;
      peak_new  = (mag > peak_ff) ? mag : peak_ff;
      fill_new  = fill_ff + FW'(1);
      emit_last = (FW'(rd_idx_ff) == blk_len_ff - FW'(1));
      hold_dec  = (hold_ff == 3'd0) ? 3'd0 : hold_ff - 3'd1;
      grow_prod = g11_ff * bpl_pkg::RECIP_TEN;
      grow_q    = grow_prod[bpl_pkg::RECIP_SHIFT +: 17];

      state_in     = state_ff;
      limit_in     = limit_ff;
      ceiling_in   = ceiling_ff;
      fill_in      = fill_ff;
      blk_len_in   = blk_len_ff;
      rd_idx_in    = rd_idx_ff;
      peak_in      = peak_ff;
      gain_in      = gain_ff;
      hold_in      = hold_ff;
      g11_in       = g11_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;
      div_start    = 1'b0;
      issue        = '0;

      if (csr_write) begin
         case (csr_index)
            bpl_pkg::CSR_LIMIT_ENABLE: limit_in = csr_data[0];
            bpl_pkg::CSR_CEILING:      ceiling_in = bpl_pkg::clamp_ceiling(csr_data);
            default: ;
         endcase
      end

      // output register: freed by a transfer, refilled from the pipe or the bypass
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (res_tag.valid) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.sample_out = res_sample;
            rsp_data_in.run_last   = res_tag.last;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!limit_ff) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.sample_out = bpl_pkg::clamp_round(req_data.sample_in);
                  rsp_data_in.run_last   = 1'b1;
               end else begin
                  st_wr_en = 1'b1;
                  fill_in  = fill_new;
                  peak_in  = peak_new;
                  if (req_data.block_end || fill_new == FW'(BLOCK_DEPTH)) begin
                     blk_len_in = fill_new;
                     rd_idx_in  = '0;
                     if (peak_new > {2'b00, ceiling_ff, 8'h00}) begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               if ({1'b0, div_res.quot} < gain_ff) gain_in = {1'b0, div_res.quot};
               hold_in  = 3'(HOLD_BLOCKS);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               st_rd_en    = 1'b1;
               issue.valid = 1'b1;
               issue.last  = emit_last;
               rd_idx_in   = rd_idx_ff + AW'(1);
               if (emit_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // gain feeds the multiply stage, so it changes only once the pipe is empty
            if (!scale_busy) begin
               hold_in = hold_dec;
               fill_in = '0;
               peak_in = '0;
               if (hold_dec == 3'd0 && gain_ff < bpl_pkg::GAIN_ONE) state_in = ST_GROW_MUL;
               else state_in = ST_IDLE;
            end
         end
         ST_GROW_MUL: begin
            g11_in   = {gain_ff, 3'b000} + {2'b00, gain_ff, 1'b0} + {3'b000, gain_ff};
            state_in = ST_GROW_DIV;
         end
         ST_GROW_DIV: begin
            gain_in  = (grow_q > bpl_pkg::GAIN_ONE) ? bpl_pkg::GAIN_ONE : grow_q;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= 1'b0;
         ceiling_ff   <= bpl_pkg::CEIL_HIGH;
         fill_ff      <= '0;
         blk_len_ff   <= '0;
         rd_idx_ff    <= '0;
         peak_ff      <= '0;
         gain_ff      <= bpl_pkg::GAIN_ONE;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         ceiling_ff   <= ceiling_in;
         fill_ff      <= fill_in;
         blk_len_ff   <= blk_len_in;
         rd_idx_ff    <= rd_idx_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      g11_ff      <= g11_in;
      rsp_data_ff <= rsp_data_in;
   end

   bpl_store #(
      .DEPTH (BLOCK_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_data.sample_in),
      .rd_en   (st_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (st_rd_data)
   );

   bpl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .ceiling (ceiling_ff),
      .divisor (peak_new),
      .res     (div_res)
   );

   bpl_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .issue      (issue),
      .rd_data    (st_rd_data),
      .gain       (gain_ff),
      .res_tag    (res_tag),
      .res_sample (res_sample),
      .busy       (scale_busy)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/bpl_store.sv]
// sample store: one write port, one registered read port
module bpl_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [24:0]   wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic signed [24:0]   rd_data
);

   logic signed [24:0] mem [DEPTH];
   logic signed [24:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bpl_div.sv]
// restoring divider: floor(ceiling * 2^24 / peak), one quotient bit per cycle
module bpl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [14:0]           ceiling,
   input  logic [24:0]           divisor,
   output bpl_pkg::div_res_type  res
);

   logic [24:0] rem_ff, rem_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [15:0] quot_ff, quot_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [25:0] shifted;
   logic        fits;

   always_comb begin
      // quotient stays below 2^16, so the upper dividend bits start as remainder
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {2'b00, ceiling, 8'h00};
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = bpl_pkg::DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in  = 25'(shifted - {1'b0, dvs_ff});
            quot_in = {quot_ff[14:0], 1'b1};
         end else begin
            rem_in  = shifted[24:0];
            quot_in = {quot_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;

endmodule

[sv/bpl_scale.sv]
// scaling pipe: store read stage, gain multiply stage, round and saturate
module bpl_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  bpl_pkg::tag_type        issue,
   input  logic signed [24:0]      rd_data,
   input  logic [16:0]             gain,
   output bpl_pkg::tag_type        res_tag,
   output logic signed [15:0]      res_sample,
   output logic                    busy
);

   bpl_pkg::tag_type   tag1_ff, tag2_ff;
   logic signed [42:0] prod_ff, prod_in;

   always_comb begin
      prod_in = rd_data * $signed({1'b0, gain});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (advance) begin
         tag1_ff <= issue;
         tag2_ff <= tag1_ff;
      end
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign res_tag    = tag2_ff;
   assign res_sample = bpl_pkg::round_sat(prod_ff);
   assign busy       = tag1_ff.valid | tag2_ff.valid;

endmodule

[sv/bpl_checker.sv]
// port-level checks of the block peak limiter, bound to the top level
module bpl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input bpl_pkg::req_type       req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bpl_pkg::rsp_type       rsp_data,
   input logic                   csr_write,
   input bpl_pkg::csr_index_type csr_index,
   input logic [14:0]            csr_data
);

   logic limit_ff;

   // mirror of the limiting mode as written through the register port
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 1'b0;
      end else if (csr_write && csr_index == bpl_pkg::CSR_LIMIT_ENABLE) begin
         limit_ff <= csr_data[0];
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while the result register is stalled");

   a_bypass_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !limit_ff && !csr_write |=>
         rsp_valid && rsp_data.run_last && rsp_data.sample_out != -16'sd32768)
      else $error("clamp-mode transfer did not give one clamped result");

endmodule

bind block_peak_limiter_core bpl_checker u_bpl_checker (.*);

[test/limiter_checker.sv]
// scoreboard for block_peak_limiter_core: predicts every output sample and compares transfers
module limiter_checker #(
   parameter int BLOCK_DEPTH = 64,
   parameter int HOLD_BLOCKS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  bpl_pkg::req_type       req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bpl_pkg::rsp_type       rsp_data,
   input  logic                   csr_write,
   input  bpl_pkg::csr_index_type csr_index,
   input  logic [14:0]            csr_data,
   output int                     failures,
   output int                     pending,
   output int                     compared
);
   timeunit 1ns;
   timeprecision 1ps;

   bit               limiting;
   logic [14:0]      ceiling_q;
   longint           block_samples[64];
   int               fill;
   longint           block_peak;
   longint           gain;
   int               hold_left;
   bpl_pkg::rsp_type samples_due[$];

   initial begin
      failures = 0;
      compared = 0;
      pending  = 0;
   end

   // one accepted input sample: queue whatever output samples it releases
   task automatic absorb_sample(input bpl_pkg::req_type item);
      longint           v;
      longint           mag;
      longint           quotient;
      longint           scaled;
      bpl_pkg::rsp_type r;
      int               i;
      v = $signed(item.sample_in);
      if (!limiting) begin
         if (v > 32767 * 256) r.sample_out = 16'sd32767;
         else if (v < -32767 * 256) r.sample_out = -16'sd32767;
         else r.sample_out = 16'((v + 128) >>> 8);
         r.run_last = 1'b1;
         samples_due.push_back(r);
         return;
      end
      mag = (v < 0) ? -v : v;
      block_samples[fill % 64] = v;
      fill = (fill + 1) % 128;
      if (mag > block_peak) block_peak = mag;
      if (!item.block_end && fill < BLOCK_DEPTH) return;

      // gain only ever drops here; recovery happens after the hold
      if (block_peak > longint'(ceiling_q) * 256) begin
         quotient = (longint'(ceiling_q) << 24) / block_peak;
         if (quotient < gain) gain = quotient;
         hold_left = HOLD_BLOCKS;
      end
      for (i = 0; i < fill; i++) begin
         scaled = (block_samples[i] * gain + (longint'(1) << 23)) >>> 24;
         if (scaled > 32767) scaled = 32767;
         else if (scaled < -32768) scaled = -32768;
         r.sample_out = 16'(scaled);
         r.run_last   = (i == fill - 1);
         samples_due.push_back(r);
      end
      if (hold_left > 0) hold_left--;
      if (hold_left == 0 && gain < bpl_pkg::GAIN_ONE) begin
         gain = gain * 11 / 10;
         if (gain > bpl_pkg::GAIN_ONE) gain = bpl_pkg::GAIN_ONE;
      end
      fill       = 0;
      block_peak = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limiting   = 1'b0;
         ceiling_q  = bpl_pkg::CEIL_HIGH;
         fill       = 0;
         block_peak = 0;
         gain       = bpl_pkg::GAIN_ONE;
         hold_left  = 0;
         samples_due.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == bpl_pkg::CSR_LIMIT_ENABLE) limiting = csr_data[0];
            else if (csr_data < bpl_pkg::CEIL_LOW) ceiling_q = bpl_pkg::CEIL_LOW;
            else if (csr_data > bpl_pkg::CEIL_HIGH) ceiling_q = bpl_pkg::CEIL_HIGH;
            else ceiling_q = csr_data;
         end
         if (req_valid && req_ready) absorb_sample(req_data);
         if (rsp_valid && rsp_ready) begin
            if (samples_due.size() == 0) begin
               $error("result transfer with nothing expected: sample_out %0d run_last %0d",
                      rsp_data.sample_out, rsp_data.run_last);
               failures++;
            end else begin
               if (rsp_data.sample_out !== samples_due[0].sample_out) begin
                  $error("sample_out: expected %0d, got %0d",
                         samples_due[0].sample_out, rsp_data.sample_out);
                  failures++;
               end
               if (rsp_data.run_last !== samples_due[0].run_last) begin
                  $error("run_last: expected %0d, got %0d",
                         samples_due[0].run_last, rsp_data.run_last);
                  failures++;
               end
               void'(samples_due.pop_front());
               compared++;
            end
         end
      end
      pending <= samples_due.size();
   end

endmodule

[test/testbench.sv]
// top of the block_peak_limiter_core testbench: clock, reset, stimulus, output stalls, verdict
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_ITEMS  = 470;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int SENDER        = 0;
   localparam int RECEIVER      = 1;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   bpl_pkg::req_type       req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bpl_pkg::rsp_type       rsp_data;
   logic                   csr_write = 1'b0;
   bpl_pkg::csr_index_type csr_index = bpl_pkg::CSR_LIMIT_ENABLE;
   logic [14:0]            csr_data  = '0;

   int failures;
   int pending;
   int compared;
   int sent_count  = 0;
   int phase_count = 0;
   int csr_writes  = 0;
   int calm_left[2] = '{0, 0};
   bit calm_on[2]   = '{0, 0};

   block_peak_limiter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   limiter_checker results_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending),
      .compared  (compared)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("block_peak_limiter_core verification failed");
      $finish;
   end

   // idle cycles before the next transfer; stretches of back-to-back traffic come and go
   function automatic int draw_wait(input int side);
      if (calm_left[side] == 0) begin
         calm_left[side] = $urandom_range(5, 40);
         calm_on[side]   = ($urandom_range(0, 3) == 0);
      end
      calm_left[side]--;
      return calm_on[side] ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic signed [24:0] pick_sample();
      int unsigned        kind;
      logic signed [24:0] s;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: s = 25'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0:       s = 25'sd16777215;
               1:       s = 25'sh1000000;
               2:       s = 25'sd8388352;
               3:       s = -25'sd8388352;
               4:       s = 25'sd0;
               default: s = -25'sd1;
            endcase
         end
         3, 4, 5: s = 25'($urandom_range(29000 * 256, 33000 * 256));
         default: s = 25'($urandom_range(0, 20000 * 256));
      endcase
      if (kind >= 3 && $urandom_range(0, 1) == 1) s = -s;
      return s;
   endfunction

   task automatic send_sample(input logic signed [24:0] value, input logic last);
      int gap;
      gap = draw_wait(SENDER);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{sample_in: value, block_end: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // stop offering, wait for every predicted output, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input bpl_pkg::csr_index_type idx, input logic [14:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   // result side: random stalls, plus two long hold-offs that back the block up
   initial begin
      int stall;
      int results;
      results = 0;
      forever begin
         stall = (results == 120 || results == 360) ? LONG_HOLD : draw_wait(RECEIVER);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results++;
      end
   end

   initial begin
      int          n;
      int          odds;
      int          target;
      bit          on;
      logic [14:0] ceil_value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clamp mode: range ends, clamp thresholds and rounding ties
      send_sample(25'sd16777215, 1'b0);
      send_sample(25'sh1000000, 1'b1);
      send_sample(25'sd8388352, 1'b0);
      send_sample(25'sd8388353, 1'b1);
      send_sample(-25'sd8388352, 1'b0);
      send_sample(-25'sd8388353, 1'b0);
      send_sample(25'sd127, 1'b1);
      send_sample(25'sd128, 1'b0);
      send_sample(-25'sd128, 1'b0);
      send_sample(-25'sd129, 1'b1);
      send_sample(25'sd0, 1'b0);
      drain_results();

      write_register(bpl_pkg::CSR_LIMIT_ENABLE, 15'h0001);
      write_register(bpl_pkg::CSR_CEILING, 15'd0);
      // peak exactly at the ceiling does not limit
      send_sample(25'sd7680000, 1'b1);
      send_sample(25'sd16777215, 1'b0);
      send_sample(-25'sd1000, 1'b0);
      send_sample(25'sd300000, 1'b0);
      drain_results();

      // clamp mode in the middle of a block; stored samples come out with the next block
      write_register(bpl_pkg::CSR_LIMIT_ENABLE, 15'h7FFE);
      send_sample(-25'sd129, 1'b1);
      send_sample(25'sd128, 1'b0);
      drain_results();
      write_register(bpl_pkg::CSR_LIMIT_ENABLE, 15'h7FFF);
      write_register(bpl_pkg::CSR_CEILING, 15'h7FFF);
      send_sample(25'sh1000000, 1'b1);
      // single-sample blocks under the ceiling: hold runs out, then gain recovers
      repeat (6) send_sample(25'sd8000000, 1'b1);

      target = sent_count + SAMPLE_ITEMS;
      while (sent_count < target) begin
         drain_results();
         on = ($urandom_range(0, 9) < 7);
         write_register(bpl_pkg::CSR_LIMIT_ENABLE, {14'($urandom), on});
         case ($urandom_range(0, 5))
            0:       ceil_value = bpl_pkg::CEIL_LOW;
            1:       ceil_value = bpl_pkg::CEIL_HIGH;
            2:       ceil_value = 15'($urandom_range(0, bpl_pkg::CEIL_LOW - 1));
            3:       ceil_value = 15'($urandom_range(bpl_pkg::CEIL_HIGH + 1, 32767));
            default: ceil_value = 15'($urandom_range(bpl_pkg::CEIL_LOW, bpl_pkg::CEIL_HIGH));
         endcase
         write_register(bpl_pkg::CSR_CEILING, ceil_value);
         // some phases rarely flag an end, so blocks close on a full store
         if ($urandom_range(0, 5) == 0) begin
            odds = 1000;
            n    = $urandom_range(64, 130);
         end else begin
            odds = $urandom_range(0, 15);
            n    = $urandom_range(8, 50);
         end
         if (n > target - sent_count) n = target - sent_count;
         repeat (n) send_sample(pick_sample(), $urandom_range(0, odds) == 0);
         phase_count++;
      end
      drain_results();

      $display("sent %0d samples over %0d random register settings, %0d register writes",
               sent_count, phase_count, csr_writes);
      $display("compared %0d output samples in limiting and clamp modes", compared);
      if (failures == 0 && pending == 0) begin
         $display("block_peak_limiter_core verification clean");
      end else begin
         $display("block_peak_limiter_core verification failed");
      end
      $finish;
   end

endmodule
